/* rtl/core/cmc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cmc_pkg;

  // field widths
  localparam int unsigned CmdW      = 2;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned SpeedCfgW = 11;
  localparam int unsigned AccelW    = 8;
  localparam int unsigned ModeW     = 3;
  localparam int unsigned PosW      = 7;
  localparam int unsigned SpeedW    = 12;
  localparam int unsigned VelW      = 13;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 32;

  // configuration reset values
  localparam logic [SpeedCfgW-1:0] MoveSpeedRst = SpeedCfgW'(500);
  localparam logic [AccelW-1:0]    AccelStepRst = AccelW'(6);
  localparam logic [TimeW-1:0]     MaxMoveRst   = TimeW'(30000);

  // reported positions in percent
  localparam logic [PosW-1:0] PosOpen = PosW'(100);
  localparam logic [PosW-1:0] PosHalf = PosW'(50);
  localparam logic [PosW-1:0] PosZero = PosW'(0);

  typedef enum logic [ModeW-1:0] {
    MODE_STOPPED = 3'd0,
    MODE_CLOSED  = 3'd1,
    MODE_OPENING = 3'd2,
    MODE_CLOSING = 3'd3,
    MODE_OPEN    = 3'd4
  } mode_e;

  typedef enum logic [CmdW-1:0] {
    CMD_NONE  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MOVE_SPEED = 2'd0,
    CFG_ACCEL_STEP = 2'd1,
    CFG_MAX_MOVE   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [SpeedCfgW-1:0] travel_speed;
    logic [AccelW-1:0]    accel_step;
    logic [TimeW-1:0]     max_move_ms;
  } cfg_t;

  typedef struct packed {
    logic [ModeW-1:0]         mode;
    logic signed [SpeedW-1:0] speed_now;
    logic signed [SpeedW-1:0] speed_target;
    logic [TimeW-1:0]         move_start;
    logic                     enable_line;
  } state_t;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic             stall_event;
    logic [TimeW-1:0] now_ms;
  } tick_t;

  typedef struct packed {
    logic [ModeW-1:0]      cover_mode;
    logic                  mode_changed;
    logic [PosW-1:0]       reported_position;
    logic                  velocity_write;
    logic signed [VelW-1:0] velocity;
    logic                  enable_n;
    logic                  driver_reset_pulse;
  } result_t;

  // position percent shown for a mode
  function automatic logic [PosW-1:0] position_of(input logic [ModeW-1:0] m);
    logic [PosW-1:0] pos;
    pos = PosZero;
    if (m == MODE_OPEN) begin
      pos = PosOpen;
    end else if (m == MODE_OPENING || m == MODE_STOPPED) begin
      pos = PosHalf;
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/cover_motor_controller_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Cover motor controller: one control tick in, one result out.
// Input stream (s_axis_*): each transaction is one tick with a command, a stall
// flag and a millisecond timestamp. Output stream (m_axis_*): each transaction
// carries the new cover mode, position, the velocity sent to the driver, the
// driver enable line and the stall reset pulse.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 move speed, 1 acceleration step, 2 move timeout); other indexes are ignored.
// Pipeline: an accepted tick is captured in the input register, worked out
// combinationally against the held mode and velocity state, and its result is
// captured in the result register, two register stages in all.
// Throughput: one tick per cycle while the receiver takes results; the state
// update is combinational between the input register and the result register.
// Reset: mode stopped, velocities and move start zero, driver disabled,
// registers at 500 / 6 / 30000, both streams empty.
// Receiver stall: the result register holds; the input register keeps one more
// tick, then s_axis_tready drops until the result is taken.
module cover_motor_controller_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [cmc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [cmc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // tick input
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // command[1:0], stall_event[2], now_ms[34:3], zero fill [39:35]
  input  wire logic [cmc_pkg::InDataW-1:0]   s_axis_tdata,
  // result output
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // cover_mode[2:0], mode_changed[3], reported_position[10:4],
  // velocity_write[11], velocity[24:12], enable_n[25], driver_reset_pulse[26],
  // zero fill [31:27]
  output logic [cmc_pkg::OutDataW-1:0]       m_axis_tdata
);

  cmc_pkg::cfg_t    cfg;
  cmc_pkg::state_t  state_q, state_d;
  cmc_pkg::tick_t   tick_q;
  cmc_pkg::result_t res_d, res_q;
  logic             in_vld_q;
  logic             out_vld_q;
  logic             advance;

  cmc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cmc_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .tick_i   (tick_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // the held tick moves on when the result register is free or being read
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      tick_q.command     <= s_axis_tdata[1:0];
      tick_q.stall_event <= s_axis_tdata[2];
      tick_q.now_ms      <= s_axis_tdata[34:3];
    end
  end

  // controller state, updated once per processed tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode         <= cmc_pkg::MODE_STOPPED;
      state_q.speed_now    <= '0;
      state_q.speed_target <= '0;
      state_q.move_start   <= '0;
      state_q.enable_line  <= 1'b1;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0,
                          res_q.driver_reset_pulse,
                          res_q.enable_n,
                          res_q.velocity,
                          res_q.velocity_write,
                          res_q.reported_position,
                          res_q.mode_changed,
                          res_q.cover_mode};

endmodule

`default_nettype wire

/* rtl/core/cmc_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module cmc_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [cmc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [cmc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output cmc_pkg::cfg_t                     cfg_o
);

  cmc_pkg::cfg_t cfg_q, cfg_d;

  // register index decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cmc_pkg::CFG_MOVE_SPEED: cfg_d.travel_speed = cfg_wdata_i[cmc_pkg::SpeedCfgW-1:0];
        cmc_pkg::CFG_ACCEL_STEP: cfg_d.accel_step   = cfg_wdata_i[cmc_pkg::AccelW-1:0];
        cmc_pkg::CFG_MAX_MOVE:   cfg_d.max_move_ms  = cfg_wdata_i[cmc_pkg::TimeW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.travel_speed <= cmc_pkg::MoveSpeedRst;
      cfg_q.accel_step   <= cmc_pkg::AccelStepRst;
      cfg_q.max_move_ms  <= cmc_pkg::MaxMoveRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/core/cmc_step.sv */
`timescale 1ns / 1ps
`default_nettype none

module cmc_step (
  input  wire cmc_pkg::cfg_t   cfg_i,
  input  wire cmc_pkg::state_t state_i,
  input  wire cmc_pkg::tick_t  tick_i,
  output cmc_pkg::state_t      state_o,
  output cmc_pkg::result_t     result_o
);

  logic [cmc_pkg::TimeW-1:0]     elapsed;
  logic                          timeout;
  logic [cmc_pkg::ModeW-1:0]     next_mode;
  logic                          changed;
  logic                          wrote;
  logic signed [cmc_pkg::VelW-1:0] vel;
  logic signed [cmc_pkg::VelW-1:0] now_ext;
  logic signed [cmc_pkg::VelW-1:0] tgt_ext;
  logic signed [cmc_pkg::VelW-1:0] acc_ext;
  logic signed [cmc_pkg::VelW-1:0] stepped;
  logic signed [cmc_pkg::SpeedW-1:0] spd_pos;
  cmc_pkg::state_t st;

  // move timeout, difference wraps modulo 2^32
  assign elapsed = tick_i.now_ms - state_i.move_start;
  assign timeout = elapsed > cfg_i.max_move_ms;

  // timeout, then command, then stall redirect
  always_comb begin
    next_mode = state_i.mode;
    if (timeout) begin
      next_mode = cmc_pkg::MODE_STOPPED;
    end
    case (tick_i.command)
      cmc_pkg::CMD_OPEN:  next_mode = cmc_pkg::MODE_OPENING;
      cmc_pkg::CMD_CLOSE: next_mode = cmc_pkg::MODE_CLOSING;
      cmc_pkg::CMD_STOP:  next_mode = cmc_pkg::MODE_STOPPED;
      default: ;
    endcase
    if (tick_i.stall_event) begin
      if (state_i.mode == cmc_pkg::MODE_OPENING) begin
        next_mode = cmc_pkg::MODE_OPEN;
      end else if (state_i.mode == cmc_pkg::MODE_CLOSING) begin
        next_mode = cmc_pkg::MODE_CLOSED;
      end else begin
        next_mode = cmc_pkg::MODE_STOPPED;
      end
    end
  end

  assign spd_pos = $signed({1'b0, cfg_i.travel_speed});

  // mode change handling and velocity ramp
  always_comb begin
    st      = state_i;
    changed = 1'b0;
    wrote   = 1'b0;
    vel     = '0;
    if (tick_i.stall_event) begin
      st.enable_line = 1'b0;
    end
    if (next_mode != state_i.mode) begin
      changed = 1'b1;
      st.mode = next_mode;
      if (next_mode == cmc_pkg::MODE_OPENING) begin
        st.move_start   = tick_i.now_ms;
        st.speed_target = spd_pos;
      end else if (next_mode == cmc_pkg::MODE_CLOSING) begin
        st.move_start   = tick_i.now_ms;
        st.speed_target = -spd_pos;
      end else begin
        st.speed_target = '0;
      end
      if (st.speed_target == '0) begin
        st.speed_now   = '0;
        wrote          = 1'b1;
        st.enable_line = 1'b1;
      end else begin
        st.enable_line = 1'b0;
      end
    end

    now_ext = cmc_pkg::VelW'(st.speed_now);
    tgt_ext = cmc_pkg::VelW'(st.speed_target);
    acc_ext = $signed({{(cmc_pkg::VelW-cmc_pkg::AccelW){1'b0}}, cfg_i.accel_step});
    stepped = now_ext;
    if (tgt_ext > now_ext) begin
      stepped = now_ext + acc_ext;
      wrote   = 1'b1;
      vel     = stepped;
      st.speed_now = (stepped > tgt_ext) ? st.speed_target
                                         : stepped[cmc_pkg::SpeedW-1:0];
    end else if (tgt_ext < now_ext) begin
      stepped = now_ext - acc_ext;
      wrote   = 1'b1;
      vel     = stepped;
      st.speed_now = (stepped < tgt_ext) ? st.speed_target
                                         : stepped[cmc_pkg::SpeedW-1:0];
    end
  end

  assign state_o = st;

  assign result_o.cover_mode         = st.mode;
  assign result_o.mode_changed       = changed;
  assign result_o.reported_position  = cmc_pkg::position_of(st.mode);
  assign result_o.velocity_write     = wrote;
  assign result_o.velocity           = vel;
  assign result_o.enable_n           = st.enable_line;
  assign result_o.driver_reset_pulse = tick_i.stall_event;

endmodule

`default_nettype wire

/* rtl/core/cmc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module cmc_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [cmc_pkg::OutDataW-1:0] m_axis_tdata
);

  logic [cmc_pkg::ModeW-1:0] mode;
  logic [cmc_pkg::PosW-1:0]  pos;
  logic                      changed;
  logic                      wrote;
  logic [cmc_pkg::VelW-1:0]  vel;
  logic                      en_n;
  logic                      pulse;

  assign mode    = m_axis_tdata[2:0];
  assign changed = m_axis_tdata[3];
  assign pos     = m_axis_tdata[10:4];
  assign wrote   = m_axis_tdata[11];
  assign vel     = m_axis_tdata[24:12];
  assign en_n    = m_axis_tdata[25];
  assign pulse   = m_axis_tdata[26];

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // position follows the reported mode
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pos == cmc_pkg::position_of(mode))
    else $error("position does not match mode");

  // no velocity value without a driver write
  a_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !wrote |-> vel == '0)
    else $error("velocity nonzero without write");

  // a stall without a mode change leaves the driver enabled
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && pulse && !changed |-> !en_n)
    else $error("driver disabled after stall pulse");

  // stopped, open and closed modes always write a zero stop velocity on entry
  a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && changed && (mode == cmc_pkg::MODE_STOPPED ||
      mode == cmc_pkg::MODE_OPEN || mode == cmc_pkg::MODE_CLOSED)
      |-> wrote && en_n && vel == '0)
    else $error("mode entry without driver stop");

endmodule

bind cover_motor_controller_top cmc_checker u_cmc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
